// ----- rtl/afl_pkg.sv -----
// Package for the attitude fusion and low-pass block.
// Holds the word types, the configuration register map, reset values and the
// fixed filter coefficients. No dependencies.
package afl_pkg;

  // Width of every sample field on the ports.
  localparam int unsigned FIELD_W = 16;
  // Width of a Q14 filter coefficient.
  localparam int unsigned COEF_W = 16;
  // Width of the gyro gain register.
  localparam int unsigned GAIN_W = 15;

  // Fixed-point shifts.
  localparam int unsigned QSHIFT     = 14;
  localparam int unsigned FUSE_SHIFT = 3;
  localparam int unsigned BIAS_SHIFT = 10;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_A0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_A1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_A2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_B1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_B2    = 3'd5;

  typedef struct packed {
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
  } coef_t;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd133;

  localparam coef_t YAW_COEF_RESET = '{
    a0: 16'sd15,
    a1: 16'sd31,
    a2: 16'sd15,
    b1: -16'sd31313,
    b2: 16'sd14991
  };

  localparam coef_t VERT_COEF = '{
    a0: 16'sd1105,
    a1: 16'sd2210,
    a2: 16'sd1105,
    b1: -16'sd18727,
    b2: 16'sd6763
  };

  typedef struct packed {
    logic                      roll_enable;
    logic                      pitch_enable;
    logic                      yaw_enable;
    logic                      alt_enable;
    logic signed [FIELD_W-1:0] gyro_roll_rate;
    logic signed [FIELD_W-1:0] gyro_pitch_rate;
    logic signed [FIELD_W-1:0] gyro_yaw_rate;
    logic signed [FIELD_W-1:0] accel_roll_tilt;
    logic signed [FIELD_W-1:0] accel_pitch_tilt;
    logic signed [FIELD_W-1:0] accel_vertical;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] roll_angle_out;
    logic signed [FIELD_W-1:0] pitch_angle_out;
    logic signed [FIELD_W-1:0] yaw_rate_out;
    logic signed [FIELD_W-1:0] vertical_accel_out;
  } out_t;

endpackage

// ----- rtl/attitude_fusion_and_lowpass.sv -----
// Top level of the attitude fusion and low-pass block.
// Depends on afl_pkg, afl_cfg, afl_fuse and afl_biquad.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------
//   input    | in_valid_i / in_ready_o | in_data_i (in_t, one sample set)
//   output   | out_valid_o/out_ready_i | out_data_o (out_t, four results)
//   config   | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// A word is registered on acceptance and its results are registered when it
// moves on to the result register, which a low out_ready_i can hold off.
// The filter state updates in the same cycle as the result register, which
// lets a new word follow at one word per cycle while the output is not stalled.
// When the result register is held by a low out_ready_i, one more word is
// still taken into the input register. Reset clears all filter state and
// loads the register defaults.
module attitude_fusion_and_lowpass import afl_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic              in_valid_q;
  in_t               in_q;
  logic              out_valid_q;
  out_t              out_q, out_d;
  logic              fire;
  logic              in_accept;
  logic [GAIN_W-1:0] gain;
  coef_t             yaw_coef;

  logic signed [SAMPLE_WIDTH-1:0] roll_rate, roll_ref, pitch_rate, pitch_ref;
  logic signed [SAMPLE_WIDTH-1:0] yaw_x, vert_x;
  logic signed [SAMPLE_WIDTH-1:0] roll_est, pitch_est, yaw_y, vert_y;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  afl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .gain_o      (gain),
    .yaw_coef_o  (yaw_coef)
  );

  always_comb begin
    roll_rate  = SAMPLE_WIDTH'(in_q.gyro_roll_rate);
    roll_ref   = SAMPLE_WIDTH'(in_q.accel_roll_tilt);
    pitch_rate = SAMPLE_WIDTH'(in_q.gyro_pitch_rate);
    pitch_ref  = SAMPLE_WIDTH'(in_q.accel_pitch_tilt);
    yaw_x      = SAMPLE_WIDTH'(in_q.gyro_yaw_rate);
    vert_x     = SAMPLE_WIDTH'(in_q.accel_vertical);
  end

  afl_fuse #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (fire && in_q.roll_enable),
    .gain_i (gain),
    .rate_i (roll_rate),
    .ref_i  (roll_ref),
    .est_o  (roll_est)
  );

  afl_fuse #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (fire && in_q.pitch_enable),
    .gain_i (gain),
    .rate_i (pitch_rate),
    .ref_i  (pitch_ref),
    .est_o  (pitch_est)
  );

  afl_biquad #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (fire && in_q.yaw_enable),
    .coef_i (yaw_coef),
    .x_i    (yaw_x),
    .y_o    (yaw_y)
  );

  afl_biquad #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_vert (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (fire && in_q.alt_enable),
    .coef_i (VERT_COEF),
    .x_i    (vert_x),
    .y_o    (vert_y)
  );

  // Results leave as the low bits of the state, zero-filled when narrower.
  always_comb begin
    out_d.roll_angle_out     = FIELD_W'($unsigned(roll_est));
    out_d.pitch_angle_out    = FIELD_W'($unsigned(pitch_est));
    out_d.yaw_rate_out       = FIELD_W'($unsigned(yaw_y));
    out_d.vertical_accel_out = FIELD_W'($unsigned(vert_y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result register not loaded after a transfer");

  a_accept_fills_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_valid_q)
    else $error("input register empty after an accepted word");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_q))
    else $error("input register lost a word while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("result changed while stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before it was taken");

endmodule

// ----- rtl/afl_cfg.sv -----
// Configuration registers: gyro gain and the yaw biquad coefficients.
// Depends on afl_pkg for the register map and reset values.
module afl_cfg import afl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [GAIN_W-1:0]     gain_o,
  output coef_t                 yaw_coef_o
);

  logic [GAIN_W-1:0] gain_q;
  coef_t             yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      yaw_q  <= YAW_COEF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GYRO_GAIN: gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_YAW_A0:    yaw_q.a0 <= cfg_wdata_i;
        CFG_YAW_A1:    yaw_q.a1 <= cfg_wdata_i;
        CFG_YAW_A2:    yaw_q.a2 <= cfg_wdata_i;
        CFG_YAW_B1:    yaw_q.b1 <= cfg_wdata_i;
        CFG_YAW_B2:    yaw_q.b2 <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign gain_o     = gain_q;
  assign yaw_coef_o = yaw_q;

endmodule

// ----- rtl/afl_fuse.sv -----
// One axis of the complementary filter with gyro bias tracking.
// Depends on afl_pkg for the shift constants and coefficient width.
module afl_fuse import afl_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           upd_i,
  input  logic [GAIN_W-1:0]              gain_i,
  input  logic signed [SAMPLE_WIDTH-1:0] rate_i,
  input  logic signed [SAMPLE_WIDTH-1:0] ref_i,
  output logic signed [SAMPLE_WIDTH-1:0] est_o
);

  localparam int unsigned PW = SAMPLE_WIDTH + COEF_W;

  logic signed [SAMPLE_WIDTH-1:0] est_q, est_d;
  logic signed [SAMPLE_WIDTH-1:0] bias_q, bias_d;
  logic signed [SAMPLE_WIDTH-1:0] rate_c;
  logic signed [PW-1:0]           prod;
  logic signed [SAMPLE_WIDTH-1:0] est_int;
  logic signed [SAMPLE_WIDTH:0]   err_a;
  logic signed [SAMPLE_WIDTH:0]   err_b;
  logic signed [SAMPLE_WIDTH-1:0] est_fused;

  always_comb begin
    rate_c  = rate_i - bias_q;
    prod    = rate_c * $signed({1'b0, gain_i});
    est_int = est_q + prod[SAMPLE_WIDTH+QSHIFT-1:QSHIFT];
    // Errors are formed one bit wider so the shifted value is exact.
    err_a     = {est_int[SAMPLE_WIDTH-1], est_int} - {ref_i[SAMPLE_WIDTH-1], ref_i};
    est_fused = est_int
              - {{(FUSE_SHIFT-1){err_a[SAMPLE_WIDTH]}}, err_a[SAMPLE_WIDTH:FUSE_SHIFT]};
    err_b   = {est_fused[SAMPLE_WIDTH-1], est_fused} - {ref_i[SAMPLE_WIDTH-1], ref_i};
    bias_d  = bias_q
            + {{(BIAS_SHIFT-1){err_b[SAMPLE_WIDTH]}}, err_b[SAMPLE_WIDTH:BIAS_SHIFT]};
    est_d   = est_fused;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q  <= '0;
      bias_q <= '0;
    end else if (upd_i) begin
      est_q  <= est_d;
      bias_q <= bias_d;
    end
  end

  assign est_o = upd_i ? est_d : est_q;

endmodule

// ----- rtl/afl_biquad.sv -----
// Second-order direct-form biquad with Q14 coefficients and wrapping state.
// Depends on afl_pkg for the coefficient type and shift constant.
module afl_biquad import afl_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           upd_i,
  input  coef_t                          coef_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  output logic signed [SAMPLE_WIDTH-1:0] y_o
);

  localparam int unsigned PW = SAMPLE_WIDTH + COEF_W;

  logic signed [SAMPLE_WIDTH-1:0] xh0_q, xh1_q, yh0_q, yh1_q;
  logic signed [PW-1:0]           p_a0, p_a1, p_a2, p_b1, p_b2;
  logic signed [SAMPLE_WIDTH-1:0] y_d;

  // Each product is shifted down by QSHIFT before the sum; only the low
  // SAMPLE_WIDTH bits of each term matter since the sum wraps.
  always_comb begin
    p_a0 = x_i   * $signed(coef_i.a0);
    p_a1 = xh0_q * $signed(coef_i.a1);
    p_a2 = xh1_q * $signed(coef_i.a2);
    p_b1 = yh0_q * $signed(coef_i.b1);
    p_b2 = yh1_q * $signed(coef_i.b2);
    y_d  = p_a0[SAMPLE_WIDTH+QSHIFT-1:QSHIFT]
         + p_a1[SAMPLE_WIDTH+QSHIFT-1:QSHIFT]
         + p_a2[SAMPLE_WIDTH+QSHIFT-1:QSHIFT]
         - p_b1[SAMPLE_WIDTH+QSHIFT-1:QSHIFT]
         - p_b2[SAMPLE_WIDTH+QSHIFT-1:QSHIFT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh0_q <= '0;
      xh1_q <= '0;
      yh0_q <= '0;
      yh1_q <= '0;
    end else if (upd_i) begin
      xh1_q <= xh0_q;
      yh1_q <= yh0_q;
      xh0_q <= x_i;
      yh0_q <= y_d;
    end
  end

  assign y_o = upd_i ? y_d : yh0_q;

endmodule
